>>> design/bth_pkg.sv
`timescale 1ns / 1ps

package bth_pkg;

   // Arena geometry. Every block start is a multiple of SLOT_BYTES, so the
   // header store keeps one slot per eight bytes of the arena.
   localparam int ARENA_BYTES  = 65536;
   localparam int HEADER_BYTES = 24;
   localparam int ALIGN_BYTES  = 8;
   localparam int MIN_PAYLOAD  = 8;
   localparam int SLOT_SHIFT   = 3;
   localparam int SLOT_BYTES   = 1 << SLOT_SHIFT;
   localparam int NUM_SLOTS    = ARENA_BYTES / SLOT_BYTES;
   localparam int IDX_W        = $clog2(NUM_SLOTS);
   localparam int HDR_SLOTS    = HEADER_BYTES / SLOT_BYTES;
   localparam int INIT_SIZE    = ARENA_BYTES - 2 * HEADER_BYTES;
   localparam int SENT_IDX     = (ARENA_BYTES - HEADER_BYTES) / SLOT_BYTES;
   localparam int SPLIT_MARGIN = MIN_PAYLOAD + HEADER_BYTES;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   typedef logic [IDX_W-1:0] idx_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_NOFIT  = 2'd1,
      ST_DOUBLE = 2'd2
   } status_type;

   typedef struct packed {
      logic [15:0] size;
      logic [15:0] bsize;
      idx_type     next;
      idx_type     prev;
      logic        free;
      logic        bfree;
      logic        has_next;
      logic        has_prev;
      logic        valid;
   } hdr_type;

   // Read address sources.
   typedef enum logic [3:0] {
      A_HEAD,
      A_RDNEXT,
      A_CUR,
      A_CUR_FWD,
      A_CUR_BACK,
      A_TAIL,
      A_FREE,
      A_AFT,
      A_UNEXT,
      A_UPREV,
      A_USELF,
      A_UFWD
   } asel_type;

   // Modifications applied to the last header read before it is written back.
   typedef enum logic [4:0] {
      WM_SPLIT_BASE,
      WM_SPLIT_TAIL,
      WM_A_EXACT,
      WM_A_SPLIT,
      WM_FREE1,
      WM_BFREE1,
      WM_SIZE_N,
      WM_BSIZE_N,
      WM_BEYOND,
      WM_VALID0,
      WM_U_NEXT,
      WM_U_PREV,
      WM_U_SELF,
      WM_U_SELF_TAKE,
      WM_U_SELF_DROP,
      WM_PUSH,
      WM_HEADPREV
   } wmod_type;

   typedef enum logic [1:0] {
      NSZ_ENT,
      NSZ_BEF,
      NSZ_AFT
   } nsz_type;

   typedef struct packed {
      logic     clr_step;
      logic     ld_req;
      logic     rd_en;
      asel_type asel;
      logic     wr_en;
      wmod_type wmod;
      logic     ld_cur;
      logic     ld_cur_u;
      logic     ld_ent;
      logic     ld_u_rd;
      logic     ld_grant;
      logic     ld_nsz;
      nsz_type  nsz_sel;
      logic     ld_aft;
      logic     set_head;
      logic     unlink_head;
      logic     ld_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic clr_done;
      logic func;
      logic req_zero;
      logic sz_over;
      logic hv;
      logic addr_null;
      logic addr_bad;
      logic rd_valid;
      logic rd_free;
      logic rd_has_next;
      logic rd_exact;
      logic rd_split;
      logic cur_is_head;
      logic ent_bfree;
      logic u_has_next;
      logic u_has_prev;
   } dp_stat_type;

endpackage

>>> design/bth_req_if.sv
`timescale 1ns / 1ps

interface bth_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [15:0] request_size;
   logic [15:0] block_address;

   modport source (output valid, func, request_size, block_address, input ready);
   modport sink (input valid, func, request_size, block_address, output ready);
endinterface

>>> design/bth_rsp_if.sv
`timescale 1ns / 1ps

interface bth_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] granted_address;
   logic [1:0]  status;

   modport source (output valid, granted_address, status, input ready);
   modport sink (input valid, granted_address, status, output ready);
endinterface

>>> design/bth_dpath.sv
`timescale 1ns / 1ps

module bth_dpath import bth_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  dp_cmd_type  cmd,
   output dp_stat_type stat,
   input  logic        req_func,
   input  logic [15:0] req_request_size,
   input  logic [15:0] req_block_address,
   output logic [15:0] rsp_granted_address
);

   hdr_type mem [NUM_SLOTS];

   hdr_type     rd_ff;
   idx_type     rdaddr_ff;
   idx_type     clr_ff, clr_in;
   idx_type     head_ff, head_in;
   logic        hv_ff, hv_in;
   logic        func_ff, func_in;
   logic        zero_ff, zero_in;
   logic [16:0] sz_ff, sz_in;
   logic [15:0] addr_ff, addr_in;
   idx_type     cur_ff, cur_in;
   hdr_type     ent_ff, ent_in;
   idx_type     u_idx_ff, u_idx_in;
   hdr_type     u_ent_ff, u_ent_in;
   idx_type     aft_ff, aft_in;
   logic [15:0] nsz_ff, nsz_in;
   logic [15:0] grant_ff, grant_in;
   logic [15:0] rsp_addr_ff, rsp_addr_in;

   idx_type     raddr;
   idx_type     waddr;
   hdr_type     wdata;
   logic        we;
   hdr_type     init_hdr;
   logic [15:0] rest;
   logic [15:0] rq_min;
   logic [16:0] rq_round;

   assign rest = ent_ff.size - 16'(HEADER_BYTES) - sz_ff[15:0];

   always_comb begin
      case (cmd.asel)
         A_HEAD:     raddr = head_ff;
         A_RDNEXT:   raddr = rd_ff.next;
         A_CUR:      raddr = cur_ff;
         A_CUR_FWD:  raddr = cur_ff + idx_type'(HDR_SLOTS) + idx_type'(ent_ff.size >> SLOT_SHIFT);
         A_CUR_BACK: raddr = cur_ff - idx_type'(HDR_SLOTS)
                             - idx_type'(ent_ff.bsize >> SLOT_SHIFT);
         A_TAIL:     raddr = cur_ff + idx_type'(ent_ff.size >> SLOT_SHIFT)
                             - idx_type'(sz_ff[15:0] >> SLOT_SHIFT);
         A_FREE:     raddr = idx_type'((addr_ff - 16'(HEADER_BYTES)) >> SLOT_SHIFT);
         A_AFT:      raddr = aft_ff;
         A_UNEXT:    raddr = u_ent_ff.next;
         A_UPREV:    raddr = u_ent_ff.prev;
         A_USELF:    raddr = u_idx_ff;
         A_UFWD:     raddr = u_idx_ff + idx_type'(HDR_SLOTS)
                             + idx_type'(u_ent_ff.size >> SLOT_SHIFT);
         default:    raddr = cur_ff;
      endcase
   end

   always_comb begin
      init_hdr = '0;
      if (clr_ff == idx_type'(0)) begin
         init_hdr.size  = 16'(INIT_SIZE);
         init_hdr.free  = 1'b1;
         init_hdr.valid = 1'b1;
      end else if (clr_ff == idx_type'(SENT_IDX)) begin
         init_hdr.bsize = 16'(INIT_SIZE);
         init_hdr.bfree = 1'b1;
      end
   end

   always_comb begin
      wdata = rd_ff;
      case (cmd.wmod)
         WM_SPLIT_BASE: wdata.size = rest;
         WM_SPLIT_TAIL: begin
            wdata.size     = sz_ff[15:0];
            wdata.bsize    = rest;
            wdata.free     = 1'b0;
            wdata.bfree    = 1'b1;
            wdata.valid    = 1'b1;
            wdata.has_next = 1'b0;
            wdata.has_prev = 1'b0;
         end
         WM_A_EXACT: wdata.bfree = 1'b0;
         WM_A_SPLIT: begin
            wdata.bsize = sz_ff[15:0];
            wdata.bfree = 1'b0;
         end
         WM_FREE1:   wdata.free  = 1'b1;
         WM_BFREE1:  wdata.bfree = 1'b1;
         WM_SIZE_N:  wdata.size  = nsz_ff;
         WM_BSIZE_N: wdata.bsize = nsz_ff;
         WM_BEYOND: begin
            wdata.bsize = nsz_ff;
            wdata.bfree = 1'b1;
         end
         WM_VALID0: wdata.valid = 1'b0;
         WM_U_NEXT: begin
            wdata.prev     = u_ent_ff.prev;
            wdata.has_prev = u_ent_ff.has_prev;
         end
         WM_U_PREV: begin
            wdata.next     = u_ent_ff.next;
            wdata.has_next = u_ent_ff.has_next;
         end
         WM_U_SELF: begin
            wdata.has_next = 1'b0;
            wdata.has_prev = 1'b0;
         end
         WM_U_SELF_TAKE: begin
            wdata.has_next = 1'b0;
            wdata.has_prev = 1'b0;
            wdata.free     = 1'b0;
         end
         WM_U_SELF_DROP: begin
            wdata.has_next = 1'b0;
            wdata.has_prev = 1'b0;
            wdata.valid    = 1'b0;
         end
         WM_PUSH: begin
            wdata.next     = head_ff;
            wdata.has_next = hv_ff;
            wdata.has_prev = 1'b0;
         end
         WM_HEADPREV: begin
            wdata.prev     = cur_ff;
            wdata.has_prev = 1'b1;
         end
         default: wdata = rd_ff;
      endcase
      waddr = rdaddr_ff;
      we    = cmd.wr_en;
      if (cmd.clr_step) begin
         waddr = clr_ff;
         wdata = init_hdr;
         we    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (cmd.rd_en) begin
         rd_ff     <= mem[raddr];
         rdaddr_ff <= raddr;
      end
   end

   always_comb begin
      rq_min   = (req_request_size < 16'(MIN_PAYLOAD)) ? 16'(MIN_PAYLOAD) : req_request_size;
      rq_round = ({1'b0, rq_min} + 17'(ALIGN_BYTES - 1)) & ~17'(ALIGN_BYTES - 1);

      clr_in      = cmd.clr_step ? clr_ff + idx_type'(1) : clr_ff;
      head_in     = head_ff;
      hv_in       = hv_ff;
      func_in     = func_ff;
      zero_in     = zero_ff;
      sz_in       = sz_ff;
      addr_in     = addr_ff;
      cur_in      = cur_ff;
      ent_in      = ent_ff;
      u_idx_in    = u_idx_ff;
      u_ent_in    = u_ent_ff;
      aft_in      = aft_ff;
      nsz_in      = nsz_ff;
      grant_in    = grant_ff;
      rsp_addr_in = rsp_addr_ff;

      if (cmd.ld_req) begin
         func_in  = req_func;
         zero_in  = (req_request_size == 16'd0);
         sz_in    = rq_round;
         addr_in  = req_block_address;
         grant_in = '0;
      end
      if (cmd.ld_cur) begin
         cur_in = raddr;
      end
      if (cmd.ld_cur_u) begin
         cur_in = u_idx_ff;
      end
      if (cmd.ld_ent) begin
         ent_in = rd_ff;
      end
      if (cmd.ld_u_rd) begin
         u_idx_in = rdaddr_ff;
         u_ent_in = rd_ff;
      end
      if (cmd.ld_aft) begin
         aft_in = raddr;
      end
      if (cmd.ld_grant) begin
         grant_in = {rdaddr_ff, SLOT_SHIFT'(0)} + 16'(HEADER_BYTES);
      end
      if (cmd.ld_nsz) begin
         case (cmd.nsz_sel)
            NSZ_ENT: nsz_in = rd_ff.size;
            NSZ_BEF: nsz_in = rd_ff.size + ent_ff.size + 16'(HEADER_BYTES);
            NSZ_AFT: nsz_in = nsz_ff + rd_ff.size + 16'(HEADER_BYTES);
            default: nsz_in = nsz_ff;
         endcase
      end
      if (cmd.unlink_head) begin
         head_in = u_ent_ff.next;
         hv_in   = u_ent_ff.has_next;
      end
      if (cmd.set_head) begin
         head_in = cur_ff;
         hv_in   = 1'b1;
      end
      if (cmd.ld_rsp) begin
         rsp_addr_in = grant_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff  <= '0;
         head_ff <= '0;
         hv_ff   <= 1'b1;
      end else begin
         clr_ff  <= clr_in;
         head_ff <= head_in;
         hv_ff   <= hv_in;
      end
      func_ff     <= func_in;
      zero_ff     <= zero_in;
      sz_ff       <= sz_in;
      addr_ff     <= addr_in;
      cur_ff      <= cur_in;
      ent_ff      <= ent_in;
      u_idx_ff    <= u_idx_in;
      u_ent_ff    <= u_ent_in;
      aft_ff      <= aft_in;
      nsz_ff      <= nsz_in;
      grant_ff    <= grant_in;
      rsp_addr_ff <= rsp_addr_in;
   end

   always_comb begin
      stat.clr_done    = (clr_ff == idx_type'(NUM_SLOTS - 1));
      stat.func        = func_ff;
      stat.req_zero    = zero_ff;
      stat.sz_over     = sz_ff[16];
      stat.hv          = hv_ff;
      stat.addr_null   = (addr_ff == 16'd0);
      stat.addr_bad    = (addr_ff < 16'(HEADER_BYTES))
                         || (addr_ff[SLOT_SHIFT-1:0] != '0);
      stat.rd_valid    = rd_ff.valid;
      stat.rd_free     = rd_ff.free;
      stat.rd_has_next = rd_ff.has_next;
      stat.rd_exact    = ({1'b0, rd_ff.size} == sz_ff);
      stat.rd_split    = ({2'b00, rd_ff.size} >= ({1'b0, sz_ff} + 18'(SPLIT_MARGIN)));
      stat.cur_is_head = (cur_ff == head_ff);
      stat.ent_bfree   = ent_ff.bfree;
      stat.u_has_next  = u_ent_ff.has_next;
      stat.u_has_prev  = u_ent_ff.has_prev;
   end

   assign rsp_granted_address = rsp_addr_ff;

endmodule

>>> design/bth_ctrl.sv
`timescale 1ns / 1ps

module bth_ctrl import bth_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output status_type  rsp_status
);

   typedef enum logic [5:0] {
      S_CLR, S_IDLE, S_DISP, S_DONE,
      A_CHK, EX_A_RD, EX_A_W, SP_BASE_W, SP_T_RD, SP_T_W, SP_A_RD, SP_A_W,
      F_CHK, F_AFT_RD, F_AFT_W, F_BEF, F_BEF_CAP, F_BEF_W, F_BA_RD, F_BA_W,
      F_BV_RD, F_BV_W, F_NXT_RD, F_NXT_CHK, F_MB_RD, F_MB_W, F_BY_RD, F_BY_W,
      P_RD, P_W, P_H_RD, P_H_W,
      U_BEG, U_WN, U_PV, U_WP, U_RS, U_WS
   } state_type;

   typedef enum logic [1:0] {
      UK_TAKE,
      UK_KEEP,
      UK_DROP
   } ukind_type;

   state_type  state_ff, state_in;
   state_type  ret_ff, ret_in;
   ukind_type  ukind_ff, ukind_in;
   status_type stat_ff, stat_in;
   logic       rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff, rsp_status_in;

   always_comb begin
      cmd           = '0;
      state_in      = state_ff;
      ret_in        = ret_ff;
      ukind_in      = ukind_ff;
      stat_in       = stat_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      req_ready     = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.ld_req = 1'b1;
               state_in   = S_DISP;
            end
         end
         S_DISP: begin
            if (stat.func == FUNC_ALLOC) begin
               if (stat.req_zero || stat.sz_over || !stat.hv) begin
                  stat_in  = ST_NOFIT;
                  state_in = S_DONE;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.asel   = A_HEAD;
                  cmd.ld_cur = 1'b1;
                  state_in   = A_CHK;
               end
            end else if (stat.addr_null) begin
               stat_in  = ST_OK;
               state_in = S_DONE;
            end else if (stat.addr_bad) begin
               stat_in  = ST_NOFIT;
               state_in = S_DONE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.asel   = A_FREE;
               cmd.ld_cur = 1'b1;
               state_in   = F_CHK;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.ld_rsp    = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_status_in = stat_ff;
               state_in      = S_IDLE;
            end
         end
         A_CHK: begin
            if (stat.rd_exact) begin
               if (stat.cur_is_head && !stat.rd_has_next) begin
                  stat_in  = ST_NOFIT;
                  state_in = S_DONE;
               end else begin
                  cmd.ld_ent   = 1'b1;
                  cmd.ld_grant = 1'b1;
                  cmd.ld_u_rd  = 1'b1;
                  ukind_in     = UK_TAKE;
                  ret_in       = EX_A_RD;
                  state_in     = U_BEG;
               end
            end else if (stat.rd_split) begin
               cmd.ld_ent = 1'b1;
               state_in   = SP_BASE_W;
            end else if (stat.rd_has_next) begin
               cmd.rd_en  = 1'b1;
               cmd.asel   = A_RDNEXT;
               cmd.ld_cur = 1'b1;
            end else begin
               stat_in  = ST_NOFIT;
               state_in = S_DONE;
            end
         end
         EX_A_RD: begin
            cmd.rd_en = 1'b1;
            cmd.asel  = A_CUR_FWD;
            state_in  = EX_A_W;
         end
         EX_A_W: begin
            cmd.wr_en = 1'b1;
            cmd.wmod  = WM_A_EXACT;
            stat_in   = ST_OK;
            state_in  = S_DONE;
         end
         SP_BASE_W: begin
            cmd.wr_en = 1'b1;
            cmd.wmod  = WM_SPLIT_BASE;
            state_in  = SP_T_RD;
         end
         SP_T_RD: begin
            cmd.rd_en = 1'b1;
            cmd.asel  = A_TAIL;
            state_in  = SP_T_W;
         end
         SP_T_W: begin
            cmd.wr_en    = 1'b1;
            cmd.wmod     = WM_SPLIT_TAIL;
            cmd.ld_grant = 1'b1;
            state_in     = SP_A_RD;
         end
         SP_A_RD: begin
            cmd.rd_en = 1'b1;
            cmd.asel  = A_CUR_FWD;
            state_in  = SP_A_W;
         end
         SP_A_W: begin
            cmd.wr_en = 1'b1;
            cmd.wmod  = WM_A_SPLIT;
            stat_in   = ST_OK;
            state_in  = S_DONE;
         end
         F_CHK: begin
            if (!stat.rd_valid) begin
               stat_in  = ST_NOFIT;
               state_in = S_DONE;
            end else if (stat.rd_free) begin
               stat_in  = ST_DOUBLE;
               state_in = S_DONE;
            end else begin
               cmd.ld_ent  = 1'b1;
               cmd.ld_nsz  = 1'b1;
               cmd.nsz_sel = NSZ_ENT;
               cmd.wr_en   = 1'b1;
               cmd.wmod    = WM_FREE1;
               state_in    = F_AFT_RD;
            end
         end
         F_AFT_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.asel   = A_CUR_FWD;
            cmd.ld_aft = 1'b1;
            state_in   = F_AFT_W;
         end
         F_AFT_W: begin
            cmd.wr_en = 1'b1;
            cmd.wmod  = WM_BFREE1;
            state_in  = F_BEF;
         end
         F_BEF: begin
            if (stat.ent_bfree) begin
               cmd.rd_en = 1'b1;
               cmd.asel  = A_CUR_BACK;
               state_in  = F_BEF_CAP;
            end else begin
               state_in = F_NXT_RD;
            end
         end
         F_BEF_CAP: begin
            cmd.ld_nsz  = 1'b1;
            cmd.nsz_sel = NSZ_BEF;
            cmd.ld_u_rd = 1'b1;
            state_in    = F_BEF_W;
         end
         F_BEF_W: begin
            cmd.wr_en = 1'b1;
            cmd.wmod  = WM_SIZE_N;
            state_in  = F_BA_RD;
         end
         F_BA_RD: begin
            cmd.rd_en = 1'b1;
            cmd.asel  = A_AFT;
            state_in  = F_BA_W;
         end
         F_BA_W: begin
            cmd.wr_en = 1'b1;
            cmd.wmod  = WM_BSIZE_N;
            ukind_in  = UK_KEEP;
            ret_in    = F_BV_RD;
            state_in  = U_BEG;
         end
         F_BV_RD: begin
            cmd.rd_en = 1'b1;
            cmd.asel  = A_CUR;
            state_in  = F_BV_W;
         end
         F_BV_W: begin
            cmd.wr_en    = 1'b1;
            cmd.wmod     = WM_VALID0;
            cmd.ld_cur_u = 1'b1;
            state_in     = F_NXT_RD;
         end
         F_NXT_RD: begin
            cmd.rd_en = 1'b1;
            cmd.asel  = A_AFT;
            state_in  = F_NXT_CHK;
         end
         F_NXT_CHK: begin
            if (stat.rd_free) begin
               cmd.ld_u_rd = 1'b1;
               cmd.ld_nsz  = 1'b1;
               cmd.nsz_sel = NSZ_AFT;
               state_in    = F_MB_RD;
            end else begin
               state_in = P_RD;
            end
         end
         F_MB_RD: begin
            cmd.rd_en = 1'b1;
            cmd.asel  = A_CUR;
            state_in  = F_MB_W;
         end
         F_MB_W: begin
            cmd.wr_en = 1'b1;
            cmd.wmod  = WM_SIZE_N;
            state_in  = F_BY_RD;
         end
         F_BY_RD: begin
            cmd.rd_en = 1'b1;
            cmd.asel  = A_UFWD;
            state_in  = F_BY_W;
         end
         F_BY_W: begin
            cmd.wr_en = 1'b1;
            cmd.wmod  = WM_BEYOND;
            ukind_in  = UK_DROP;
            ret_in    = P_RD;
            state_in  = U_BEG;
         end
         P_RD: begin
            cmd.rd_en = 1'b1;
            cmd.asel  = A_CUR;
            state_in  = P_W;
         end
         P_W: begin
            cmd.wr_en = 1'b1;
            cmd.wmod  = WM_PUSH;
            if (stat.hv) begin
               state_in = P_H_RD;
            end else begin
               cmd.set_head = 1'b1;
               stat_in      = ST_OK;
               state_in     = S_DONE;
            end
         end
         P_H_RD: begin
            cmd.rd_en = 1'b1;
            cmd.asel  = A_HEAD;
            state_in  = P_H_W;
         end
         P_H_W: begin
            cmd.wr_en    = 1'b1;
            cmd.wmod     = WM_HEADPREV;
            cmd.set_head = 1'b1;
            stat_in      = ST_OK;
            state_in     = S_DONE;
         end
         U_BEG: begin
            if (stat.u_has_next) begin
               cmd.rd_en = 1'b1;
               cmd.asel  = A_UNEXT;
               state_in  = U_WN;
            end else begin
               state_in = U_PV;
            end
         end
         U_WN: begin
            cmd.wr_en = 1'b1;
            cmd.wmod  = WM_U_NEXT;
            state_in  = U_PV;
         end
         U_PV: begin
            if (stat.u_has_prev) begin
               cmd.rd_en = 1'b1;
               cmd.asel  = A_UPREV;
               state_in  = U_WP;
            end else begin
               cmd.unlink_head = 1'b1;
               state_in        = U_RS;
            end
         end
         U_WP: begin
            cmd.wr_en = 1'b1;
            cmd.wmod  = WM_U_PREV;
            state_in  = U_RS;
         end
         U_RS: begin
            cmd.rd_en = 1'b1;
            cmd.asel  = A_USELF;
            state_in  = U_WS;
         end
         U_WS: begin
            cmd.wr_en = 1'b1;
            case (ukind_ff)
               UK_TAKE: cmd.wmod = WM_U_SELF_TAKE;
               UK_DROP: cmd.wmod = WM_U_SELF_DROP;
               default: cmd.wmod = WM_U_SELF;
            endcase
            state_in = ret_ff;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLR;
         ret_ff        <= S_IDLE;
         ukind_ff      <= UK_KEEP;
         stat_ff       <= ST_OK;
         rsp_valid_ff  <= 1'b0;
         rsp_status_ff <= ST_OK;
      end else begin
         state_ff      <= state_in;
         ret_ff        <= ret_in;
         ukind_ff      <= ukind_in;
         stat_ff       <= stat_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;

endmodule

>>> design/boundary_tag_heap_allocator_unit.sv
`timescale 1ns / 1ps

// Channel  Dir  Word fields                              Handshake
// req_if   in   func, request_size, block_address        valid / ready
// rsp_if   out  granted_address, status                  valid / ready
//
// After reset a clearing pass writes all 8192 header slots, one per cycle,
// and no word is taken until that pass is done.
// An allocate is accepted and dispatched, walks the free list node by node,
// updates headers and then gives its result; a free is a series of
// read-modify-write passes on the single header port.
// One word is in work at a time; a finished result sits in the output
// register while the next word is accepted, and rsp stalls never lose it.

module boundary_tag_heap_allocator_unit import bth_pkg::*; (
   input logic       clock,
   input logic       reset,
   bth_req_if.sink   req_if,
   bth_rsp_if.source rsp_if
);

   dp_cmd_type  cmd;
   dp_stat_type stat;
   status_type  rsp_status;

   // The controller sequences the free-list walk and every header update;
   // the datapath owns the header store, the list head and the work registers.
   bth_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .stat       (stat),
      .cmd        (cmd),
      .req_valid  (req_if.valid),
      .req_ready  (req_if.ready),
      .rsp_valid  (rsp_if.valid),
      .rsp_ready  (rsp_if.ready),
      .rsp_status (rsp_status)
   );

   bth_dpath u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_func            (req_if.func),
      .req_request_size    (req_if.request_size),
      .req_block_address   (req_if.block_address),
      .rsp_granted_address (rsp_if.granted_address)
   );

   assign rsp_if.status = 2'(rsp_status);

endmodule

>>> tb/boundary_tag_heap_allocator_checker.sv
`timescale 1ns / 1ps

module boundary_tag_heap_allocator_checker import bth_pkg::*; (
   input  logic clock,
   input  logic reset,
   bth_req_if   req_mon,
   bth_rsp_if   rsp_mon,
   output int   errors,
   output int   pending
);

   typedef struct {
      logic [15:0] size;
      logic [15:0] bsize;
      logic [15:0] next;
      logic [15:0] prev;
      bit          free;
      bit          bfree;
      bit          has_next;
      bit          has_prev;
      bit          valid;
   } tag_type;

   typedef struct {
      logic [15:0] grant;
      status_type  st;
   } outcome_type;

   // One boundary tag per byte offset of the arena, plus the free-list head.
   tag_type     tags [ARENA_BYTES];
   int unsigned list_head;
   bit          list_head_ok;
   outcome_type awaited [$];

   function automatic int unsigned after_blk(int unsigned off);
      return (off + HEADER_BYTES + tags[off].size) % ARENA_BYTES;
   endfunction

   function automatic int unsigned before_blk(int unsigned off);
      int unsigned d;
      d = (HEADER_BYTES + tags[off].bsize) % ARENA_BYTES;
      return (off + ARENA_BYTES - d) % ARENA_BYTES;
   endfunction

   function automatic void clear_arena();
      for (int i = 0; i < ARENA_BYTES; i++) tags[i] = '{default: 0};
      tags[0].free  = 1;
      tags[0].size  = 16'(INIT_SIZE);
      tags[0].valid = 1;
      tags[ARENA_BYTES - HEADER_BYTES].bfree = 1;
      tags[ARENA_BYTES - HEADER_BYTES].bsize = 16'(INIT_SIZE);
      list_head    = 0;
      list_head_ok = 1;
   endfunction

   function automatic void unlink_blk(int unsigned off);
      if (tags[off].has_next) begin
         tags[tags[off].next].prev     = tags[off].prev;
         tags[tags[off].next].has_prev = tags[off].has_prev;
      end
      if (tags[off].has_prev) begin
         tags[tags[off].prev].next     = tags[off].next;
         tags[tags[off].prev].has_next = tags[off].has_next;
      end else begin
         list_head    = tags[off].next;
         list_head_ok = tags[off].has_next;
      end
      tags[off].has_next = 0;
      tags[off].has_prev = 0;
   endfunction

   function automatic void push_blk(int unsigned off);
      tags[off].next     = list_head[15:0];
      tags[off].has_next = list_head_ok;
      tags[off].has_prev = 0;
      if (list_head_ok) begin
         tags[list_head].prev     = off[15:0];
         tags[list_head].has_prev = 1;
      end
      list_head    = off;
      list_head_ok = 1;
   endfunction

   // Splits the tail of a free block off as a new free block and lists it.
   function automatic int unsigned carve_tail(int unsigned off, int unsigned want);
      int unsigned rest, t, a;
      rest = tags[off].size - (HEADER_BYTES + want);
      tags[off].size = rest[15:0];
      t = after_blk(off);
      tags[t].bsize = rest[15:0];
      tags[t].bfree = tags[off].free;
      tags[t].size  = want[15:0];
      tags[t].free  = 1;
      tags[t].valid = 1;
      a = after_blk(t);
      tags[a].bsize = want[15:0];
      tags[a].bfree = 1;
      push_blk(t);
      return t;
   endfunction

   function automatic outcome_type allocate(int unsigned req);
      outcome_type r;
      int unsigned want, cur, walked, taken;
      bit          found, split, more;
      r = '{grant: 16'd0, st: ST_NOFIT};
      if (req == 0) return r;
      want = (req < MIN_PAYLOAD) ? MIN_PAYLOAD : req;
      want = (want + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
      cur = list_head;
      more = list_head_ok;
      walked = 0;
      found = 0;
      split = 0;
      taken = 0;
      while (more && walked < ARENA_BYTES) begin
         if (tags[cur].size == want) begin
            found = 1;
            taken = cur;
            break;
         end
         if (tags[cur].size >= want + SPLIT_MARGIN) begin
            found = 1;
            split = 1;
            taken = cur;
            break;
         end
         more = tags[cur].has_next;
         cur = tags[cur].next;
         walked++;
      end
      if (!found) return r;
      if (split) taken = carve_tail(taken, want);
      else if (taken == list_head && !tags[list_head].has_next) return r;
      unlink_blk(taken);
      tags[taken].free = 0;
      tags[after_blk(taken)].bfree = 0;
      r.grant = 16'(taken + HEADER_BYTES);
      r.st = ST_OK;
      return r;
   endfunction

   function automatic outcome_type release_blk(int unsigned addr);
      outcome_type r;
      int unsigned off, aft, blk, bef, beyond;
      r = '{grant: 16'd0, st: ST_OK};
      if (addr == 0) return r;
      if (addr < HEADER_BYTES || !tags[addr - HEADER_BYTES].valid) begin
         r.st = ST_NOFIT;
         return r;
      end
      off = addr - HEADER_BYTES;
      if (tags[off].free) begin
         r.st = ST_DOUBLE;
         return r;
      end
      blk = off;
      tags[blk].free = 1;
      aft = after_blk(blk);
      tags[aft].bfree = 1;
      if (tags[blk].bfree) begin
         bef = before_blk(blk);
         tags[bef].size  = 16'(tags[bef].size + tags[blk].size + HEADER_BYTES);
         tags[aft].bsize = tags[bef].size;
         unlink_blk(bef);
         tags[blk].valid = 0;
         blk = bef;
      end
      if (tags[aft].free) begin
         beyond = after_blk(aft);
         tags[blk].size = 16'(tags[blk].size + tags[aft].size + HEADER_BYTES);
         tags[beyond].bsize = tags[blk].size;
         tags[beyond].bfree = 1;
         unlink_blk(aft);
         tags[aft].valid = 0;
      end
      push_blk(blk);
      return r;
   endfunction

   always @(posedge clock) begin
      outcome_type seen, want;
      if (reset) begin
         clear_arena();
         awaited.delete();
         errors = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.grant = rsp_mon.granted_address;
            seen.st = status_type'(rsp_mon.status);
            if (awaited.size() == 0) begin
               $error("unexpected result word: granted_address %0d status %0d",
                      seen.grant, seen.st);
               errors++;
            end else begin
               want = awaited.pop_front();
               if (seen.grant !== want.grant) begin
                  $error("granted_address: expected %0d, got %0d", want.grant, seen.grant);
                  errors++;
               end
               if (seen.st !== want.st) begin
                  $error("status: expected %0d, got %0d", want.st, seen.st);
                  errors++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.func == FUNC_ALLOC) awaited.push_back(allocate(req_mon.request_size));
            else awaited.push_back(release_blk(req_mon.block_address));
         end
      end
      pending = awaited.size();
   end

endmodule

>>> tb/boundary_tag_heap_allocator_unit_test.sv
`timescale 1ns / 1ps

module boundary_tag_heap_allocator_unit_test import bth_pkg::*;;

   logic clock;
   logic reset;
   int   errors;
   int   pending;

   bth_req_if req_bus ();
   bth_rsp_if rsp_bus ();

   boundary_tag_heap_allocator_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   boundary_tag_heap_allocator_checker checker_inst (
      .clock   (clock),
      .reset   (reset),
      .req_mon (req_bus),
      .rsp_mon (rsp_bus),
      .errors  (errors),
      .pending (pending)
   );

   // Percent chances, per cycle, that the sender holds back a word and that
   // the receiver stalls. Each stimulus phase sets both.
   int idle_pct;
   int stall_pct;

   // Addresses the block has granted and not yet freed, and a short history
   // of freed ones that later serve as double-free candidates.
   logic [15:0] live_addrs [$];
   logic [15:0] freed_addrs [$];
   logic [15:0] last_grant;
   int          results_seen = 0;

   initial begin
      clock = 1'b0;
      forever begin
         #5 clock = 1'b1;
         #5 clock = 1'b0;
      end
   end

   // The receiver stalls at random; with stall_pct at zero it always takes
   // the result word.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Granted addresses are harvested from the result channel so that frees
   // can target live blocks. This only steers stimulus; checking is done in
   // the checker.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         last_grant = rsp_bus.granted_address;
         if (rsp_bus.status == ST_OK && rsp_bus.granted_address != 16'd0)
            live_addrs.push_back(rsp_bus.granted_address);
         results_seen++;
      end
   end

   // Presents one word and holds it until the block accepts it. Idle cycles
   // go in front of the word, so valid is only lowered when a gap is taken.
   task automatic send_word(logic func, logic [15:0] size, logic [15:0] addr);
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.func          <= func;
      req_bus.request_size  <= size;
      req_bus.block_address <= addr;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // Sends a word and waits for its result, for the directed part where the
   // next word depends on the address just granted.
   task automatic send_and_settle(logic func, logic [15:0] size, logic [15:0] addr);
      int target;
      target = results_seen + 1;
      send_word(func, size, addr);
      req_bus.valid <= 1'b0;
      wait (results_seen >= target);
      @(posedge clock);
   endtask

   // Removes a chosen live address from the pool and remembers it as freed.
   function automatic logic [15:0] take_live(int idx);
      logic [15:0] a;
      a = live_addrs[idx];
      live_addrs.delete(idx);
      freed_addrs.push_back(a);
      if (freed_addrs.size() > 16) void'(freed_addrs.pop_front());
      return a;
   endfunction

   task automatic random_word();
      int          pick;
      logic [15:0] size;
      logic [15:0] addr;
      logic        do_alloc;
      do_alloc = (live_addrs.size() == 0) ||
                 ($urandom_range(99) < ((live_addrs.size() < 60) ? 55 : 35));
      if (do_alloc) begin
         pick = $urandom_range(99);
         if (pick < 70) size = 16'($urandom_range(256, 1));
         else if (pick < 85) size = 16'($urandom_range(31, 0));
         else if (pick < 95) size = 16'($urandom_range(4096, 257));
         else size = 16'($urandom);
         send_word(FUNC_ALLOC, size, 16'($urandom));
      end else begin
         pick = $urandom_range(99);
         if (pick < 70 && live_addrs.size() != 0)
            addr = take_live($urandom_range(live_addrs.size() - 1));
         else if (pick < 80 && freed_addrs.size() != 0)
            addr = freed_addrs[$urandom_range(freed_addrs.size() - 1)];
         else if (pick < 85)
            addr = 16'd0;
         else if (pick < 90 && live_addrs.size() != 0)
            addr = live_addrs[$urandom_range(live_addrs.size() - 1)] + 16'd8;
         else
            addr = 16'($urandom);
         send_word(FUNC_FREE, 16'($urandom), addr);
      end
   endtask

   initial begin
      logic [15:0] mid;
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.func          = FUNC_ALLOC;
      req_bus.request_size  = 16'd0;
      req_bus.block_address = 16'd0;
      idle_pct              = 0;
      stall_pct             = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part: zero and oversized requests, the sole exact fit of the
      // whole arena, minimum-size rounding, and the odd free addresses.
      send_and_settle(FUNC_ALLOC, 16'd0, 16'hFFFF);
      send_and_settle(FUNC_ALLOC, 16'hFFFF, 16'd0);
      send_and_settle(FUNC_ALLOC, 16'(INIT_SIZE), 16'd0);
      send_and_settle(FUNC_ALLOC, 16'd1, 16'd0);
      send_and_settle(FUNC_ALLOC, 16'd7, 16'd0);
      send_and_settle(FUNC_ALLOC, 16'd8, 16'd0);
      mid = last_grant;
      send_and_settle(FUNC_ALLOC, 16'd9, 16'd0);
      send_and_settle(FUNC_ALLOC, 16'd100, 16'd0);
      send_and_settle(FUNC_FREE, 16'hFFFF, 16'd0);
      send_and_settle(FUNC_FREE, 16'd0, 16'd5);
      send_and_settle(FUNC_FREE, 16'd0, 16'hFFFF);
      send_and_settle(FUNC_FREE, 16'd0, 16'(ARENA_BYTES - HEADER_BYTES));

      // The eight-byte block sits between two live blocks, so freeing it
      // leaves it apart; a second free is a double free, and an allocate of
      // the same size then takes it whole.
      live_addrs.delete(live_addrs.size() - 3);
      send_and_settle(FUNC_FREE, 16'd0, mid);
      send_and_settle(FUNC_FREE, 16'd0, mid);
      send_and_settle(FUNC_ALLOC, 16'd8, 16'd0);

      // Freeing everything coalesces back to one block; then the largest
      // request that still splits is made and returned.
      while (live_addrs.size() != 0) send_and_settle(FUNC_FREE, 16'd0, take_live(0));
      send_and_settle(FUNC_ALLOC, 16'(INIT_SIZE - SPLIT_MARGIN), 16'd0);
      while (live_addrs.size() != 0) send_and_settle(FUNC_FREE, 16'd0, take_live(0));
      freed_addrs.delete();

      // Random part in four phases of flow control.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 80; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 80; end
            default: begin idle_pct = 32; stall_pct = 32; end
         endcase
         repeat (300) random_word();
      end
      req_bus.valid <= 1'b0;

      // Waiting for a clock edge lets the checker log the last accepted word.
      @(posedge clock);
      wait (pending == 0);
      repeat (200) @(posedge clock);
      if (errors == 0) begin
         $display("boundary_tag_heap_allocator_unit_test: done, clean");
      end else begin
         $display("boundary_tag_heap_allocator_unit_test: done, errors");
      end
      $finish;
   end

   // The clearing pass after reset, long free-list walks and heavy stalls
   // all fit well inside this bound.
   initial begin
      #60ms;
      $display("boundary_tag_heap_allocator_unit_test: done, errors");
      $finish;
   end

endmodule
